/* design/crc32w_pkg.sv */
// Shared constants and the word-wide CRC update function.
package crc32w_pkg;

  localparam int unsigned CRC_W = 32;

  typedef logic [CRC_W-1:0] crc_t;

  localparam crc_t CRC_ALL_ONES   = 32'hFFFF_FFFF;
  localparam crc_t CRC_POLY_RESET = 32'h04C1_1DB7;

  // Shift one word into the remainder, MSB first; feed back the polynomial
  // whenever the old top bit differs from the data bit.
  function automatic crc_t crc_word(input crc_t rem, input crc_t word, input crc_t poly);
    crc_t r;
    r = rem;
    for (int b = CRC_W - 1; b >= 0; b--) begin
      if (r[CRC_W-1] ^ word[b]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

/* design/crc32w_if.sv */
// Valid/ready channel interfaces for message words and CRC results.
interface crc32w_word_if;
  logic                valid;
  logic                ready;
  crc32w_pkg::crc_t    data_word;
  logic                first_word;
  logic                last_word;

  modport source (output valid, output data_word, output first_word, output last_word,
                  input ready);
  modport sink   (input valid, input data_word, input first_word, input last_word,
                  output ready);
endinterface

interface crc32w_crc_if;
  logic                valid;
  logic                ready;
  crc32w_pkg::crc_t    crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

/* design/crc32_word_configurable_poly.sv */
// A word beat enters the input register; for a last word, its CRC result is then loaded
//   into the output register once that register is free to take it.
// Throughput: one word per cycle, but a last word waits for a free result slot; the
//   32-step XOR network between the input and remainder registers sets the cycle time.
// Reset (rst, synchronous): polynomial 0x04C11DB7, remainder all ones, both stages empty.
module crc32_word_configurable_poly (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  crc32w_pkg::crc_t      cfg_wr_data,
  crc32w_word_if.sink           din,
  crc32w_crc_if.source          dout
);

  crc32w_pkg::crc_t polynomial;
  crc32w_pkg::crc_t remainder;
  crc32w_pkg::crc_t remainder_next;
  crc32w_pkg::crc_t crc_start;

  // Input register
  logic             s1_valid;
  crc32w_pkg::crc_t s1_word;
  logic             s1_first;
  logic             s1_last;

  // Output register
  logic             out_valid;
  crc32w_pkg::crc_t out_crc;

  logic s1_fire;
  logic in_fire;
  logic out_free;

  assign out_free = !out_valid || dout.ready;
  // A last word needs the result slot; other words advance freely.
  assign s1_fire  = s1_valid && (!s1_last || out_free);
  assign din.ready = !s1_valid || s1_fire;
  assign in_fire  = din.valid && din.ready;

  assign crc_start      = s1_first ? crc32w_pkg::CRC_ALL_ONES : remainder;
  assign remainder_next = crc32w_pkg::crc_word(crc_start, s1_word, polynomial);

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= crc32w_pkg::CRC_POLY_RESET;
    end else if (cfg_wr_en) begin
      polynomial <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word  <= din.data_word;
      s1_first <= din.first_word;
      s1_last  <= din.last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= crc32w_pkg::CRC_ALL_ONES;
    end else if (s1_fire) begin
      remainder <= remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_crc <= remainder_next;
    end
  end

  assign dout.valid     = out_valid;
  assign dout.crc_value = out_crc;

  a_last_loads_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> out_valid && out_crc == $past(remainder_next))
    else $error("last word did not load its CRC into the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dout.ready |-> !(s1_fire && s1_last))
    else $error("pending CRC result overwritten");

  a_hold_remainder: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(remainder))
    else $error("remainder changed without a word");

  a_reset_state: assert property (@(posedge clk)
    rst |=> remainder == crc32w_pkg::CRC_ALL_ONES && !s1_valid && !out_valid)
    else $error("reset did not restore the initial state");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> din.ready)
    else $error("empty input stage refused a beat");

endmodule
